[rtl/bba_pkg.sv]
// Shared types, constants and helpers for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int WORD_W   = 32;
  localparam int WORD_LOG = 5;
  localparam int BLOCK_W  = 10;
  localparam int REQ_W    = 2;
  localparam int DATA_W   = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_MARK    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd;
    logic chk;
    logic emit;
  } bba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic direct;
    logic more;
    logic out_free;
  } bba_sts_t;

  // lowest set bit position; zero when the word is empty
  function automatic logic [WORD_LOG-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [WORD_LOG-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = WORD_LOG'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

[rtl/bba_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/bba_ctrl.sv]
// Sequencing controller: clearing pass, request read-modify-write, result hand-off.
`default_nettype none
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.direct ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.rd     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.chk    = 1'b1;
        state_next = sts.more ? ST_ISSUE : ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

[rtl/bba_dpath.sv]
// Datapath: map RAM, search hint, request registers, result and output beat registers.
`default_nettype none
module bba_dpath #(
  parameter int BLOCK_COUNT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bba_pkg::bba_cmd_t          cmd,
  output bba_pkg::bba_sts_t          sts,
  input  logic [bba_pkg::DATA_W-1:0] s_tdata,
  input  logic [bba_pkg::REQ_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bba_pkg::DATA_W-1:0] m_tdata,
  output logic                       m_tuser
);
  import bba_pkg::*;

  localparam int DEPTH    = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REM      = BLOCK_COUNT % WORD_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [WORD_W-1:0] LAST_WORD =
    (REM == 0) ? '1 : ((WORD_W'(1) << REM) - WORD_W'(1));

  logic [REQ_W-1:0]    req_q;
  logic [AW-1:0]       word_q;
  logic [WORD_LOG-1:0] bit_q;
  logic [AW-1:0]       hint;
  logic [AW-1:0]       clr_cnt;
  logic [BLOCK_W-1:0]  res_gnt;
  logic                res_stat;
  logic [BLOCK_W-1:0]  out_gnt;
  logic                out_stat;

  logic [BLOCK_W-1:0]  in_idx;
  logic [31:0]         in_idx32;
  logic                in_range;
  logic                is_alloc;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   rdata;
  logic                word_zero;
  logic [WORD_LOG-1:0] pos;
  logic [31:0]         gnt32;
  logic [WORD_W-1:0]   bit_mask;

  assign in_idx   = s_tdata[BLOCK_W-1:0];
  assign in_idx32 = 32'(in_idx);
  assign in_range = in_idx32 < 32'(BLOCK_COUNT);

  assign sts.direct = (s_tuser == REQ_ALLOC) ? 1'b0 :
                      ((s_tuser == REQ_MARK) || (s_tuser == REQ_RELEASE)) ? !in_range :
                      1'b1;

  assign is_alloc  = (req_q == REQ_ALLOC);
  assign word_zero = (rdata == '0);
  assign pos       = lowest_set(rdata);
  assign gnt32     = (32'(hint) << WORD_LOG) | 32'(pos);
  assign bit_mask  = WORD_W'(1) << bit_q;

  assign sts.clear_last = (clr_cnt == LAST);
  assign sts.more       = is_alloc && word_zero && (hint != LAST);
  assign sts.out_free   = !m_tvalid || m_tready;

  assign ram_raddr = is_alloc ? hint : word_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_raddr;
    ram_wdata = rdata;
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = (clr_cnt == LAST) ? LAST_WORD : '1;
    end else if (cmd.chk) begin
      unique case (req_q)
        REQ_ALLOC: begin
          ram_we    = !word_zero;
          ram_wdata = rdata & (rdata - WORD_W'(1));
        end
        REQ_MARK: begin
          ram_we    = 1'b1;
          ram_wdata = rdata & ~bit_mask;
        end
        REQ_RELEASE: begin
          ram_we    = 1'b1;
          ram_wdata = rdata | bit_mask;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  bba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hint     <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear_wr && !sts.clear_last) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.chk) begin
        if (sts.more) begin
          hint <= hint + AW'(1);
        end else if (req_q == REQ_RELEASE && word_q < hint) begin
          hint <= word_q;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= s_tuser;
      word_q   <= AW'(in_idx32 >> WORD_LOG);
      bit_q    <= in_idx[WORD_LOG-1:0];
      res_gnt  <= '0;
      res_stat <= STAT_OK;
    end
    if (cmd.chk && is_alloc) begin
      if (!word_zero) begin
        res_gnt <= gnt32[BLOCK_W-1:0];
      end else if (!sts.more) begin
        res_stat <= STAT_FULL;
      end
    end
    if (cmd.emit) begin
      out_gnt  <= res_gnt;
      out_stat <= res_stat;
    end
  end

  assign m_tdata = DATA_W'(out_gnt);
  assign m_tuser = out_stat;

endmodule
`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// Top level of the free-block bitmap allocator.
//
//  channel | dir | tdata                         | tuser
//  s_*     | in  | [9:0] block_index, pad to 16  | [1:0] req_type
//  m_*     | out | [9:0] granted_block, pad to 16| [0] status
//
// After rst a clearing pass writes all ceil(BLOCK_COUNT/32) map words, s_tready low.
// Mark and release: a RAM read state, then a check state that writes the word back;
// unused codes and out-of-range blocks skip the RAM. Allocate scans 32-block words upward
// from the search hint, a read and a check state each, up to a free block or the last word.
// The result register frees the input side while a beat waits on m_tready.
`default_nettype none
module bitmap_block_allocator #(
  parameter int BLOCK_COUNT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bba_pkg::DATA_W-1:0] s_tdata,   // [9:0] block_index
  input  logic [bba_pkg::REQ_W-1:0]  s_tuser,   // [1:0] req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bba_pkg::DATA_W-1:0] m_tdata,   // [9:0] granted_block
  output logic                       m_tuser    // [0] status
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bba_dpath #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
`default_nettype wire

[rtl/bba_checker.sv]
// Port-level checker for the allocator and its bind.
`default_nettype none
module bba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [bba_pkg::DATA_W-1:0] s_tdata,
  input logic [bba_pkg::REQ_W-1:0]  s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bba_pkg::DATA_W-1:0] m_tdata,
  input logic                       m_tuser
);
  import bba_pkg::*;

  logic [1:0] pend;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = s_tvalid && s_tready;
  assign acc_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(acc_in) - 2'(acc_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata == '0))
    else $error("full result carries a nonzero block");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pend != 2'd0))
    else $error("result beat with no request outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    acc_in |-> (pend == 2'd0) || (pend == 2'd1 && m_tvalid))
    else $error("request taken while another is still in work");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire

[tb/sv/tb_bitmap_block_allocator.sv]
// Self-checking stream testbench for the bitmap block allocator with a bitmap predictor.
module tb_bitmap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int BLOCK_COUNT = 1024;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_NS = 30_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic               status;
  } grant_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic [REQ_W-1:0]  s_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;

  bit [BLOCK_COUNT-1:0] free_map;
  grant_t              grant_queue[$];
  grant_t              oldest;
  logic [BLOCK_W-1:0]  last_grant;
  int                  mismatch_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;

  bitmap_block_allocator #(.BLOCK_COUNT(BLOCK_COUNT)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #WATCHDOG_NS;
    $display("[bitmap_block_allocator] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (grant_queue.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        oldest = grant_queue.pop_front();
        if (m_tdata !== DATA_W'(oldest.block)) begin
          $display("%0t granted_block: expected %h, actual %h",
                   $time, DATA_W'(oldest.block), m_tdata);
          mismatch_count++;
        end
        if (m_tuser !== oldest.status) begin
          $display("%0t status: expected %b, actual %b", $time, oldest.status, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // called and returns on a falling edge; valid stays high between back-to-back beats
  task automatic send_req(input logic [REQ_W-1:0] code, input logic [BLOCK_W-1:0] idx);
    grant_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(idx);
    s_tuser  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res.block  = '0;
    res.status = STAT_OK;
    if (code == REQ_ALLOC) begin
      res.status = STAT_FULL;
      for (int b = 0; b < BLOCK_COUNT; b++) begin
        if (free_map[b]) begin
          free_map[b] = 1'b0;
          res.block   = BLOCK_W'(b);
          res.status  = STAT_OK;
          last_grant  = res.block;
          break;
        end
      end
    end else if (code == REQ_MARK || code == REQ_RELEASE) begin
      if (idx < BLOCK_COUNT) free_map[idx] = (code == REQ_RELEASE);
    end
    grant_queue.push_back(res);
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_MARK, 10'd1023);
    send_req(REQ_MARK, 10'd1023);
    send_req(REQ_RELEASE, 10'd0);
    send_req(REQ_RELEASE, 10'd0);
    send_req(REQ_ALLOC, 10'h2AA);
    send_req(REQ_MARK, 10'd2);
    send_req(REQ_ALLOC, 10'h155);
    send_req(REQ_UNUSED, 10'h3FF);
    send_req(REQ_UNUSED, 10'h000);
    send_req(REQ_RELEASE, 10'h2AA);
    send_req(REQ_RELEASE, 10'h155);
    send_req(REQ_RELEASE, 10'd1023);
    send_req(REQ_MARK, 10'd31);
    send_req(REQ_MARK, 10'd32);
    send_req(REQ_ALLOC, 10'h000);
  endtask

  // drain every free block, then poke holes into the full map
  task automatic test_map_full();
    repeat ($countones(free_map) + 2) send_req(REQ_ALLOC, BLOCK_W'($urandom));
    send_req(REQ_MARK, 10'd500);
    send_req(REQ_UNUSED, 10'd0);
    send_req(REQ_RELEASE, 10'd1023);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_RELEASE, 10'd640);
    send_req(REQ_RELEASE, 10'd0);
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_ALLOC, 10'h3FF);
  endtask

  task automatic test_random(input int n);
    int                 sent;
    int                 sel;
    logic [BLOCK_W-1:0] base;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(99);
      if (sel < 38) begin
        send_req(REQ_ALLOC, BLOCK_W'($urandom));
      end else if (sel < 56) begin
        send_req(REQ_RELEASE, BLOCK_W'($urandom));
      end else if (sel < 70) begin
        send_req(REQ_RELEASE, last_grant);
      end else if (sel < 85) begin
        send_req(REQ_MARK, BLOCK_W'($urandom));
      end else if (sel < 95) begin
        // low blocks pull the search back behind its hint
        send_req(REQ_RELEASE, BLOCK_W'($urandom_range(63)));
      end else if (sel < 99) begin
        send_req(REQ_UNUSED, BLOCK_W'($urandom));
      end else begin
        base = BLOCK_W'($urandom_range(31) * 32);
        for (int k = 0; k < 32; k++) send_req(REQ_RELEASE, base | BLOCK_W'(k));
        sent += 31;
      end
      sent++;
    end
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = REQ_ALLOC;
    free_map       = '1;
    last_grant     = '0;
    mismatch_count = 0;
    send_idle_pct  = 33;
    recv_idle_pct  = 64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_map_full();

    send_idle_pct = 64;
    recv_idle_pct = 33;
    test_random(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);

    s_tvalid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

[bitmap_block_allocator.f]
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_dpath.sv
rtl/bitmap_block_allocator.sv
rtl/bba_checker.sv
tb/sv/tb_bitmap_block_allocator.sv
